// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, compiled out when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property checked at every rising edge outside reset
`define ASSERT_RST(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion %m failed");

// property checked at every rising edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion %m failed");

`else

`define ASSERT_RST(lbl, clk, rst_n, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// ----- rtl/core/desc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// desc_pkg
// types, constants and move arithmetic for the dual encoder step counter
// ----------------------------------------------------------------------------
package desc_pkg;

  // field widths
  localparam int ButtonW = 8;
  localparam int EncW    = 4;
  localparam int CountW  = 10;
  localparam int StepW   = 3;

  // parameter defaults
  localparam int NumButtonsDef  = 8;
  localparam int HistoryBitsDef = 16;

  // debounce pattern: released samples, then four pressed samples
  localparam logic [31:0] PressPattern = 32'h0000_000F;

  // reset values
  localparam logic [CountW-1:0] LimitReset = 10'd1023;
  localparam logic [StepW-1:0]  StepReset  = 3'd1;

  typedef logic [CountW-1:0] count_t;
  typedef logic [StepW-1:0]  step_t;
  typedef logic [1:0]        enc_pair_t;

  // active-high encoder line codes
  localparam enc_pair_t EncIdle = 2'b11;
  localparam enc_pair_t EncUp   = 2'b01;
  localparam enc_pair_t EncDown = 2'b10;

  // one encoder move applied to the count, saturating at zero and the limit
  function automatic count_t apply_move(enc_pair_t prev, enc_pair_t curr,
                                        step_t step, count_t cnt,
                                        count_t limit);
    logic [CountW:0] sum;
    count_t          res;
    sum = {1'b0, cnt} + {{(CountW + 1 - StepW){1'b0}}, step};
    res = cnt;
    if (prev == EncIdle && curr == EncUp) begin
      if (sum >= {1'b0, limit}) begin
        res = limit;
      end else begin
        res = sum[CountW-1:0];
      end
    end else if (prev == EncIdle && curr == EncDown) begin
      if ({{(CountW - StepW){1'b0}}, step} >= cnt) begin
        res = '0;
      end else begin
        res = cnt - {{(CountW - StepW){1'b0}}, step};
      end
    end
    return res;
  endfunction

endpackage

// ----- rtl/core/dual_encoder_step_counter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_encoder_step_counter
// debounced button step select and saturating two-encoder up/down count
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+------------------------------------
//  in_      | input     | in_valid/in_stall   | in_button_levels, in_encoder_levels
//  out_     | output    | out_valid/out_stall | out_count_value, out_step_now
//  cfg_     | input     | cfg_wr_en           | cfg_wr_data (count limit)
//
//  one transaction per cycle sustained while out_stall is low; the input is
//  registered first, then the result loads into the output or skid register
//  all per-item work (history shift, step select, two moves) sits in one stage
//  synchronous active-low reset clears histories, step (to one), count,
//  encoder sample and the limit (to 1023)
//  a skid register holds one extra result while out_stall is high, so input
//  stalls only once that skid register is full
//
module dual_encoder_step_counter
  import desc_pkg::*;
#(
  parameter int NUM_BUTTONS  = NumButtonsDef,
  parameter int HISTORY_BITS = HistoryBitsDef
) (
  input  logic                clk,
  input  logic                rst_n,
  // input channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [ButtonW-1:0]  in_button_levels,
  input  logic [EncW-1:0]     in_encoder_levels,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic [CountW-1:0]   out_count_value,
  output logic [StepW-1:0]    out_step_now,
  // configuration
  input  logic                cfg_wr_en,
  input  logic [CountW-1:0]   cfg_wr_data
);

  // input register
  logic                in_valid_r;
  logic [ButtonW-1:0]  button_r;
  logic [EncW-1:0]     enc_r;

  // block state
  logic [HISTORY_BITS-1:0] hist_r   [NUM_BUTTONS];
  logic [HISTORY_BITS-1:0] hist_nxt [NUM_BUTTONS];
  logic [EncW-1:0]         last_enc_r;
  step_t                   step_r, step_nxt;
  count_t                  count_r, count_nxt;
  count_t                  limit_r;

  // output and skid registers
  logic   out_valid_r, skid_valid_r;
  count_t out_count_r, skid_count_r;
  step_t  out_step_r, skid_step_r;

  logic            move;
  logic            out_free;
  logic [EncW-1:0] enc_now;
  count_t          count_mid;

  assign in_stall = in_valid_r & skid_valid_r;
  assign move     = in_valid_r & ~skid_valid_r;
  assign out_free = ~out_valid_r | ~out_stall;

  // input register, holds while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      button_r <= in_button_levels;
      enc_r    <= in_encoder_levels;
    end
  end

  // history shift and highest debounced button
  always_comb begin
    step_nxt = step_r;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      hist_nxt[i] = {hist_r[i][HISTORY_BITS-2:0], ~button_r[i]};
      if (hist_nxt[i] == PressPattern[HISTORY_BITS-1:0]) begin
        step_nxt = StepW'(i);
      end
    end
  end

  // encoder one, then encoder two
  assign enc_now   = ~enc_r;
  assign count_mid = apply_move(last_enc_r[1:0], enc_now[1:0], step_nxt, count_r,
                                limit_r);
  assign count_nxt = apply_move(last_enc_r[3:2], enc_now[3:2], step_nxt, count_mid,
                                limit_r);

  // state update on each transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        hist_r[i] <= '0;
      end
      last_enc_r <= '0;
      step_r     <= StepReset;
      count_r    <= '0;
    end else if (move) begin
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        hist_r[i] <= hist_nxt[i];
      end
      last_enc_r <= enc_now;
      step_r     <= step_nxt;
      count_r    <= count_nxt;
    end
  end

  // limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LimitReset;
    end else if (cfg_wr_en) begin
      limit_r <= cfg_wr_data;
    end
  end

  // output register with skid stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r  <= skid_valid_r | move;
      skid_valid_r <= 1'b0;
    end else if (move) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid_r) begin
        out_count_r <= skid_count_r;
        out_step_r  <= skid_step_r;
      end else begin
        out_count_r <= count_nxt;
        out_step_r  <= step_nxt;
      end
    end else if (move) begin
      skid_count_r <= count_nxt;
      skid_step_r  <= step_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_count_value = out_count_r;
  assign out_step_now    = out_step_r;

  // checks
  `include "assert_macros.svh"

  `ASSERT_RST(a_skid_needs_out, clk, rst_n, skid_valid_r |-> out_valid_r)
  `ASSERT_RST(a_move_fills_out, clk, rst_n, (move && !out_valid_r) |=> out_valid_r)
  `ASSERT_RST(a_count_holds, clk, rst_n, !move |=> $stable(count_r))
  `ASSERT_RST(a_skid_on_stall, clk, rst_n, $rose(skid_valid_r) |-> $past(out_valid_r && out_stall))

endmodule
